@@ sv/vtm_pkg.sv @@
// Shared types and constants of the vectored thruster mixer.
`default_nettype none

package vtm_pkg;

	// raw mixed values (Q30) and their magnitudes
	localparam int RAW_W = 35;
	localparam int MAG_W = 34;
	// normalized quotient, Q20, magnitude up to one
	localparam int QUO_W = 21;
	localparam int QS_W = QUO_W + 1;
	localparam int REM_W = MAG_W + 1;
	localparam int STEP_W = 5;

	// shared multiplier
	localparam int MA_W = 18;
	localparam int MB_W = 32;
	localparam int PROD_W = MA_W + MB_W;

	localparam int PWM_W = 11;
	localparam int PWM_N = 10;
	localparam int ARM_N = 3;
	localparam int THR_N = 7;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 15;

	localparam logic [15:0] COS45_Q16 = 16'd46341;
	localparam logic [MAG_W-1:0] ONE_Q30 = MAG_W'(1) << 30;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEADBAND      = 3'd0,
		REG_PWM_CENTER    = 3'd1,
		REG_PWM_HALF_SPAN = 3'd2,
		REG_BACK_VERT     = 3'd3,
		REG_SHOULDER_GAIN = 3'd4,
		REG_TILT_GAIN     = 3'd5,
		REG_TWIST_GAIN    = 3'd6
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PROD,
		ST_MAX,
		ST_DIVGO,
		ST_DIVW,
		ST_MAP,
		ST_FLUSH,
		ST_OUT
	} state_t;

	typedef enum logic [2:0] {
		WB_NONE,
		WB_PA,
		WB_PB,
		WB_PC,
		WB_ARM,
		WB_PWM_ARM,
		WB_PWM_THR
	} wb_kind_t;

	// writeback tag: where the registered product of the shared multiplier goes
	typedef struct packed {
		wb_kind_t kind;
		logic [3:0] idx;
	} wb_t;

endpackage

`default_nettype wire

@@ sv/vtm_div.sv @@
// Restoring divider, one quotient bit per cycle, for group normalization.
`default_nettype none

module vtm_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [vtm_pkg::MAG_W-1:0]   dividend,
	input  logic [vtm_pkg::MAG_W-1:0]   divisor,
	output logic                        done,
	output logic [vtm_pkg::QUO_W-1:0]   quotient
);
	import vtm_pkg::*;

	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(QUO_W - 1);

	logic busy_q;
	logic done_q;
	logic [STEP_W-1:0] cnt_q;
	logic [REM_W-1:0] rem_q;
	logic [MAG_W-1:0] div_q;
	logic [QUO_W-1:0] quo_q;
	logic ge;
	logic [REM_W-1:0] rem_sub;

	// dividend <= divisor, so remainder stays below twice the divisor
	assign ge = rem_q >= {1'b0, div_q};
	assign rem_sub = ge ? rem_q - {1'b0, div_q} : rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + STEP_W'(1);
				if (cnt_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, dividend};
			div_q <= divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= {rem_sub[REM_W-2:0], 1'b0};
			quo_q <= {quo_q[QUO_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

@@ sv/vectored_thruster_mixer.sv @@
// Top level of the vectored thruster mixer: sequencer, shared multiplier, registers.
`default_nettype none

// Mixes one teleoperation sample (signed Q2.14) into ten servo/thruster pulse
// widths in microseconds. Four horizontal thrusters are mixed at a 45 degree
// heading from forward, strafe and rotate; three vertical ones from the
// trigger difference. Each group is divided by its largest magnitude when
// that exceeds one, then thrust below the deadband, or any thrust while the
// disable latch is set, is zeroed; values map to center + half_span * value
// (rounded down, clamped to 0..2047). Arm axes are stick * gain, mapped the
// same way. The disable latch is set by disable_button or a missing pad and
// cleared by enable_button, and is updated before the sample is mixed.
// Timing: one word at a time. An accepted word passes through the products
// and arm mappings on the shared multiplier, the group maxima, the seven
// divisions on the single bit-serial divider (the dominant cost), the thrust
// mapping on the multiplier and a final writeback before its result shows on
// out_valid. in_stall is high from acceptance until the result is taken.
// Config writes (cfg_ready is always high) belong in idle periods.

module vectored_thruster_mixer (
	input  logic                              clk,
	input  logic                              arst_n,
	// config write channel
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [vtm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [vtm_pkg::CFG_DATA_W-1:0]    cfg_data,
	// input word
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [15:0]                fwd,
	input  logic signed [15:0]                strafe,
	input  logic signed [15:0]                rotate,
	input  logic [14:0]                       right_trigger,
	input  logic [14:0]                       left_trigger,
	input  logic signed [15:0]                shoulder_stick,
	input  logic signed [15:0]                tilt_stick,
	input  logic signed [15:0]                twist_stick,
	input  logic                              claw_button,
	input  logic                              enable_button,
	input  logic                              disable_button,
	input  logic                              pad_connected,
	// result word
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [vtm_pkg::PWM_W-1:0]         front_right_pwm,
	output logic [vtm_pkg::PWM_W-1:0]         back_right_pwm,
	output logic [vtm_pkg::PWM_W-1:0]         back_left_pwm,
	output logic [vtm_pkg::PWM_W-1:0]         front_left_pwm,
	output logic [vtm_pkg::PWM_W-1:0]         up_left_pwm,
	output logic [vtm_pkg::PWM_W-1:0]         up_right_pwm,
	output logic [vtm_pkg::PWM_W-1:0]         up_back_pwm,
	output logic [vtm_pkg::PWM_W-1:0]         shoulder_pwm,
	output logic [vtm_pkg::PWM_W-1:0]         tilt_pwm,
	output logic [vtm_pkg::PWM_W-1:0]         twist_pwm,
	output logic                              claw_cmd,
	output logic                              disabled_flag
);
	import vtm_pkg::*;

	// sequencer step limits
	localparam logic [3:0] LAST_PROD = 4'd8;   // 6 products + 3 arm mappings
	localparam logic [3:0] LAST_ELEM = 4'd6;   // seven thrusters

	// config registers, reset values
	localparam logic [14:0] DEADBAND_RST = 15'd1638;
	localparam logic [10:0] CENTER_RST   = 11'd1500;
	localparam logic [8:0]  HALF_RST     = 9'd400;
	localparam logic [14:0] BVG_RST      = 15'd6554;
	localparam logic [14:0] SHG_RST      = 15'd819;
	localparam logic [14:0] TLG_RST      = 15'd819;
	localparam logic [14:0] TWG_RST      = 15'd8192;

	logic [14:0] deadband_q;
	logic [10:0] center_q;
	logic [8:0]  half_q;
	logic [14:0] bvg_q;
	logic [14:0] shg_q;
	logic [14:0] tlg_q;
	logic [14:0] twg_q;

	// sequencer
	state_t state_q, state_d;
	logic [3:0] idx_q, idx_d;
	logic in_acc;

	// captured word
	logic signed [15:0] fwd_q, strafe_q, rot_q, d_q;
	logic signed [15:0] sh_q, tl_q, tw_q;
	logic claw_q;
	logic latch_q;

	// shared multiplier
	logic signed [MA_W-1:0] mul_a;
	logic signed [MB_W-1:0] mul_b;
	wb_t wb_d, wb_s1;
	logic signed [PROD_W-1:0] prod_s1;

	// intermediate results
	logic signed [RAW_W-1:0] pa_q, pb_q;
	logic signed [31:0] pc_q;
	logic signed [31:0] arm_q [ARM_N];
	logic signed [QS_W-1:0] q_q [THR_N];
	logic [PWM_W-1:0] pwm_q [PWM_N];
	logic [MAG_W-1:0] mh_q, mv_q;

	// combinational datapath
	logic signed [16:0] sum_sf, dif_sf, negd;
	logic signed [RAW_W-1:0] rot35, vd35, ub35, raw_cur, neg_raw;
	logic [MAG_W-1:0] mag_cur;
	logic div_start, div_done;
	logic [QUO_W-1:0] div_quo;
	logic q_zero;
	logic signed [QS_W-1:0] q_signed;
	logic signed [13:0] map_val;
	logic signed [14:0] map_sum;
	logic [PWM_W-1:0] pwm_map;

	assign cfg_ready = 1'b1;
	assign in_acc = in_valid && !in_stall;

	//------------------------------------------------------------------
	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadband_q <= DEADBAND_RST;
			center_q <= CENTER_RST;
			half_q <= HALF_RST;
			bvg_q <= BVG_RST;
			shg_q <= SHG_RST;
			tlg_q <= TLG_RST;
			twg_q <= TWG_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_DEADBAND:      deadband_q <= cfg_data;
				REG_PWM_CENTER:    center_q <= cfg_data[10:0];
				REG_PWM_HALF_SPAN: half_q <= cfg_data[8:0];
				REG_BACK_VERT:     bvg_q <= cfg_data;
				REG_SHOULDER_GAIN: shg_q <= cfg_data;
				REG_TILT_GAIN:     tlg_q <= cfg_data;
				REG_TWIST_GAIN:    twg_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	//------------------------------------------------------------------
	// next state
	always_comb begin
		state_d = state_q;
		idx_d = idx_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					state_d = ST_PROD;
					idx_d = '0;
				end
			end
			ST_PROD: begin
				if (idx_q == LAST_PROD) begin
					state_d = ST_MAX;
					idx_d = '0;
				end else begin
					idx_d = idx_q + 4'd1;
				end
			end
			ST_MAX: begin
				if (idx_q == LAST_ELEM) begin
					state_d = ST_DIVGO;
					idx_d = '0;
				end else begin
					idx_d = idx_q + 4'd1;
				end
			end
			ST_DIVGO: state_d = ST_DIVW;
			ST_DIVW: begin
				if (div_done) begin
					if (idx_q == LAST_ELEM) begin
						state_d = ST_MAP;
						idx_d = '0;
					end else begin
						state_d = ST_DIVGO;
						idx_d = idx_q + 4'd1;
					end
				end
			end
			ST_MAP: begin
				if (idx_q == LAST_ELEM) begin
					state_d = ST_FLUSH;
				end else begin
					idx_d = idx_q + 4'd1;
				end
			end
			ST_FLUSH: state_d = ST_OUT;
			ST_OUT: begin
				if (!out_stall) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q <= '0;
		end else begin
			state_q <= state_d;
			idx_q <= idx_d;
		end
	end

	//------------------------------------------------------------------
	// sequencer outputs: multiplier operands, writeback tag, handshakes
	assign sum_sf = {fwd_q[15], fwd_q} + {strafe_q[15], strafe_q};
	assign dif_sf = {strafe_q[15], strafe_q} - {fwd_q[15], fwd_q};

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		wb_d = '{kind: WB_NONE, idx: '0};
		div_start = 1'b0;
		in_stall = (state_q != ST_IDLE);
		out_valid = (state_q == ST_OUT);
		unique case (state_q)
			ST_PROD: begin
				unique case (idx_q)
					4'd0: begin
						mul_a = {2'b00, COS45_Q16};
						mul_b = {{15{sum_sf[16]}}, sum_sf};
						wb_d = '{kind: WB_PA, idx: '0};
					end
					4'd1: begin
						mul_a = {2'b00, COS45_Q16};
						mul_b = {{15{dif_sf[16]}}, dif_sf};
						wb_d = '{kind: WB_PB, idx: '0};
					end
					4'd2: begin
						mul_a = {3'b000, bvg_q};
						mul_b = {{16{d_q[15]}}, d_q};
						wb_d = '{kind: WB_PC, idx: '0};
					end
					4'd3: begin
						mul_a = {3'b000, shg_q};
						mul_b = {{16{sh_q[15]}}, sh_q};
						wb_d = '{kind: WB_ARM, idx: 4'd0};
					end
					4'd4: begin
						mul_a = {3'b000, tlg_q};
						mul_b = {{16{tl_q[15]}}, tl_q};
						wb_d = '{kind: WB_ARM, idx: 4'd1};
					end
					4'd5: begin
						mul_a = {3'b000, twg_q};
						mul_b = {{16{tw_q[15]}}, tw_q};
						wb_d = '{kind: WB_ARM, idx: 4'd2};
					end
					4'd6: begin
						mul_a = {9'd0, half_q};
						mul_b = arm_q[0];
						wb_d = '{kind: WB_PWM_ARM, idx: idx_q + 4'd1};
					end
					4'd7: begin
						mul_a = {9'd0, half_q};
						mul_b = arm_q[1];
						wb_d = '{kind: WB_PWM_ARM, idx: idx_q + 4'd1};
					end
					4'd8: begin
						mul_a = {9'd0, half_q};
						mul_b = arm_q[2];
						wb_d = '{kind: WB_PWM_ARM, idx: idx_q + 4'd1};
					end
					default: begin
					end
				endcase
			end
			ST_MAP: begin
				mul_a = {9'd0, half_q};
				mul_b = {{(MB_W-QS_W){q_q[idx_q[2:0]][QS_W-1]}}, q_q[idx_q[2:0]]};
				wb_d = '{kind: WB_PWM_THR, idx: idx_q};
			end
			ST_DIVGO: div_start = 1'b1;
			default: begin
			end
		endcase
	end

	// product register and its writeback tag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wb_s1 <= '{kind: WB_NONE, idx: '0};
		end else begin
			wb_s1 <= wb_d;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
	end

	//------------------------------------------------------------------
	// pulse mapping: center + floor(product / 2^frac), clamped
	always_comb begin
		if (wb_s1.kind == WB_PWM_ARM) begin
			map_val = prod_s1[41:28];
		end else begin
			map_val = prod_s1[33:20];
		end
		map_sum = $signed({4'b0000, center_q}) + 15'(map_val);
		if (map_sum < 15'sd0) begin
			pwm_map = '0;
		end else if (map_sum > 15'sd2047) begin
			pwm_map = '1;
		end else begin
			pwm_map = map_sum[PWM_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		unique case (wb_s1.kind)
			WB_PA:  pa_q <= prod_s1[RAW_W-1:0];
			WB_PB:  pb_q <= prod_s1[RAW_W-1:0];
			WB_PC:  pc_q <= prod_s1[31:0];
			WB_ARM: arm_q[wb_s1.idx[1:0]] <= prod_s1[31:0];
			WB_PWM_ARM, WB_PWM_THR: pwm_q[wb_s1.idx] <= pwm_map;
			default: begin
			end
		endcase
	end

	//------------------------------------------------------------------
	// raw Q30 mix of the current thruster, from stored products
	assign rot35 = {{3{rot_q[15]}}, rot_q, 16'h0000};
	assign negd = -{d_q[15], d_q};
	assign vd35 = {{2{negd[16]}}, negd, 16'h0000};
	assign ub35 = -{pc_q[31], pc_q, 2'b00};

	always_comb begin
		unique case (idx_q[2:0])
			3'd0: raw_cur = pa_q + rot35;     // front right
			3'd1: raw_cur = pb_q - rot35;     // back right
			3'd2: raw_cur = pa_q - rot35;     // back left
			3'd3: raw_cur = -pb_q - rot35;    // front left
			3'd4: raw_cur = vd35;             // up left
			3'd5: raw_cur = vd35;             // up right
			3'd6: raw_cur = ub35;             // up back
			default: raw_cur = '0;
		endcase
	end

	assign neg_raw = -raw_cur;
	assign mag_cur = raw_cur[RAW_W-1] ? neg_raw[MAG_W-1:0] : raw_cur[MAG_W-1:0];

	//------------------------------------------------------------------
	// input capture, disable latch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latch_q <= 1'b0;
		end else if (in_acc) begin
			if (disable_button || !pad_connected) begin
				latch_q <= 1'b1;
			end else if (enable_button) begin
				latch_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			fwd_q <= fwd;
			strafe_q <= strafe;
			rot_q <= rotate;
			d_q <= $signed({1'b0, right_trigger}) - $signed({1'b0, left_trigger});
			sh_q <= shoulder_stick;
			tl_q <= tilt_stick;
			tw_q <= twist_stick;
			claw_q <= claw_button;
		end
	end

	//------------------------------------------------------------------
	// group maxima, floor of one
	always_ff @(posedge clk) begin
		if (in_acc) begin
			mh_q <= ONE_Q30;
			mv_q <= ONE_Q30;
		end else if (state_q == ST_MAX) begin
			if (idx_q < 4'd4) begin
				if (mag_cur > mh_q) begin
					mh_q <= mag_cur;
				end
			end else if (mag_cur > mv_q) begin
				mv_q <= mag_cur;
			end
		end
	end

	//------------------------------------------------------------------
	// normalization: |raw| * 2^20 / max, then deadband and disable
	vtm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (mag_cur),
		.divisor  ((idx_q < 4'd4) ? mh_q : mv_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign q_zero = latch_q || (div_quo < {deadband_q, 6'b000000});
	assign q_signed = raw_cur[RAW_W-1] ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});

	always_ff @(posedge clk) begin
		if (state_q == ST_DIVW && div_done) begin
			q_q[idx_q[2:0]] <= q_zero ? '0 : q_signed;
		end
	end

	//------------------------------------------------------------------
	// result word
	assign front_right_pwm = pwm_q[0];
	assign back_right_pwm  = pwm_q[1];
	assign back_left_pwm   = pwm_q[2];
	assign front_left_pwm  = pwm_q[3];
	assign up_left_pwm     = pwm_q[4];
	assign up_right_pwm    = pwm_q[5];
	assign up_back_pwm     = pwm_q[6];
	assign shoulder_pwm    = pwm_q[7];
	assign tilt_pwm        = pwm_q[8];
	assign twist_pwm       = pwm_q[9];
	assign claw_cmd        = claw_q;
	assign disabled_flag   = latch_q;

endmodule

`default_nettype wire

@@ bench/vtm_mix_checker.sv @@
// Channel monitor for the vectored thruster mixer: predicts each result word and compares it.
`timescale 1ns / 100ps

module vtm_mix_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [vtm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [vtm_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	input  logic                           in_stall,
	input  logic signed [15:0]             fwd,
	input  logic signed [15:0]             strafe,
	input  logic signed [15:0]             rotate,
	input  logic [14:0]                    right_trigger,
	input  logic [14:0]                    left_trigger,
	input  logic signed [15:0]             shoulder_stick,
	input  logic signed [15:0]             tilt_stick,
	input  logic signed [15:0]             twist_stick,
	input  logic                           claw_button,
	input  logic                           enable_button,
	input  logic                           disable_button,
	input  logic                           pad_connected,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  logic [vtm_pkg::PWM_W-1:0]      front_right_pwm,
	input  logic [vtm_pkg::PWM_W-1:0]      back_right_pwm,
	input  logic [vtm_pkg::PWM_W-1:0]      back_left_pwm,
	input  logic [vtm_pkg::PWM_W-1:0]      front_left_pwm,
	input  logic [vtm_pkg::PWM_W-1:0]      up_left_pwm,
	input  logic [vtm_pkg::PWM_W-1:0]      up_right_pwm,
	input  logic [vtm_pkg::PWM_W-1:0]      up_back_pwm,
	input  logic [vtm_pkg::PWM_W-1:0]      shoulder_pwm,
	input  logic [vtm_pkg::PWM_W-1:0]      tilt_pwm,
	input  logic [vtm_pkg::PWM_W-1:0]      twist_pwm,
	input  logic                           claw_cmd,
	input  logic                           disabled_flag,
	output int                             mismatches,
	output int                             words_due
);
	import vtm_pkg::*;

	localparam int     HORIZ_N   = 4;
	localparam int     Q20_FRAC  = 20;
	localparam int     ARM_FRAC  = 28;
	localparam int     FIELD_N   = PWM_N + 2;
	localparam longint UNITY_Q30 = 64'sd1 << 30;
	localparam longint PWM_CEIL  = (64'sd1 << PWM_W) - 1;

	// pwm[0..6] thrusters, pwm[7..9] arm servos
	typedef struct packed {
		logic [PWM_N-1:0][PWM_W-1:0] pwm;
		logic                        claw;
		logic                        dis;
	} mix_word_t;

	logic [14:0]   deadband_q;
	logic [10:0]   center_q;
	logic [8:0]    half_span_q;
	logic [14:0]   back_gain_q;
	logic [14:0]   shoulder_gain_q;
	logic [14:0]   tilt_gain_q;
	logic [14:0]   twist_gain_q;
	logic          latch_q;
	mix_word_t     words_q [$];
	mix_word_t     due;
	mix_word_t     seen;
	int            fail_tally;

	assign seen = {twist_pwm, tilt_pwm, shoulder_pwm, up_back_pwm, up_right_pwm, up_left_pwm,
		front_left_pwm, back_left_pwm, back_right_pwm, front_right_pwm, claw_cmd, disabled_flag};

	function automatic longint mag64(input longint v);
		return (v < 0) ? -v : v;
	endfunction

	// center + floor(half_span * val / 2^frac), clamped to the port range
	function automatic logic [PWM_W-1:0] pulse_of(input longint val, input int frac);
		longint p;
		p = longint'(center_q) + ((longint'(half_span_q) * val) >>> frac);
		if (p < 0)
			p = 0;
		else if (p > PWM_CEIL)
			p = PWM_CEIL;
		return p[PWM_W-1:0];
	endfunction

	function automatic mix_word_t mix_sample(
		input logic signed [15:0] f, s, r,
		input logic [14:0]        rt, lt,
		input logic signed [15:0] sh, tl, tw,
		input logic               claw, en, dis, pad, latched
	);
		longint    raw [THR_N];
		longint    c45, rot, diff, top_h, top_v, q;
		mix_word_t w;
		// latch moves before the sample is mixed; disable wins over enable
		w.dis = (dis || !pad) ? 1'b1 : (en ? 1'b0 : latched);
		c45 = longint'(COS45_Q16);
		rot = longint'(r) * 65536;
		diff = longint'(rt) - longint'(lt);
		raw[0] = c45 * (longint'(s) + longint'(f)) + rot;
		raw[1] = c45 * (longint'(s) - longint'(f)) - rot;
		raw[2] = c45 * (longint'(s) + longint'(f)) - rot;
		raw[3] = c45 * (longint'(f) - longint'(s)) - rot;
		raw[4] = -diff * 65536;
		raw[5] = -diff * 65536;
		raw[6] = -diff * longint'(back_gain_q) * 4;
		top_h = UNITY_Q30;
		top_v = UNITY_Q30;
		for (int i = 0; i < THR_N; i++) begin
			if (i < HORIZ_N) begin
				if (mag64(raw[i]) > top_h)
					top_h = mag64(raw[i]);
			end else if (mag64(raw[i]) > top_v) begin
				top_v = mag64(raw[i]);
			end
		end
		for (int i = 0; i < THR_N; i++) begin
			q = (mag64(raw[i]) << Q20_FRAC) / ((i < HORIZ_N) ? top_h : top_v);
			if (raw[i] < 0)
				q = -q;
			if (w.dis || mag64(q) < longint'(deadband_q) * 64)
				q = 0;
			w.pwm[i] = pulse_of(q, Q20_FRAC);
		end
		w.pwm[THR_N]     = pulse_of(longint'(sh) * longint'(shoulder_gain_q), ARM_FRAC);
		w.pwm[THR_N + 1] = pulse_of(longint'(tl) * longint'(tilt_gain_q), ARM_FRAC);
		w.pwm[THR_N + 2] = pulse_of(longint'(tw) * longint'(twist_gain_q), ARM_FRAC);
		w.claw = claw;
		return w;
	endfunction

	function automatic int field_of(input mix_word_t w, input int k);
		if (k < PWM_N)
			return int'(w.pwm[k]);
		if (k == PWM_N)
			return int'(w.claw);
		return int'(w.dis);
	endfunction

	function automatic string field_label(input int k);
		case (k)
			0:       return "front_right_pwm";
			1:       return "back_right_pwm";
			2:       return "back_left_pwm";
			3:       return "front_left_pwm";
			4:       return "up_left_pwm";
			5:       return "up_right_pwm";
			6:       return "up_back_pwm";
			7:       return "shoulder_pwm";
			8:       return "tilt_pwm";
			9:       return "twist_pwm";
			10:      return "claw_cmd";
			default: return "disabled_flag";
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadband_q = 15'd1638;
			center_q = 11'd1500;
			half_span_q = 9'd400;
			back_gain_q = 15'd6554;
			shoulder_gain_q = 15'd819;
			tilt_gain_q = 15'd819;
			twist_gain_q = 15'd8192;
			latch_q = 1'b0;
			fail_tally = 0;
			words_q.delete();
			mismatches <= 0;
			words_due <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_DEADBAND:      deadband_q = cfg_data;
					REG_PWM_CENTER:    center_q = cfg_data[10:0];
					REG_PWM_HALF_SPAN: half_span_q = cfg_data[8:0];
					REG_BACK_VERT:     back_gain_q = cfg_data;
					REG_SHOULDER_GAIN: shoulder_gain_q = cfg_data;
					REG_TILT_GAIN:     tilt_gain_q = cfg_data;
					REG_TWIST_GAIN:    twist_gain_q = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (words_q.size() == 0) begin
					$error("result word arrived with none expected");
					fail_tally = fail_tally + 1;
				end else begin
					due = words_q.pop_front();
					for (int k = 0; k < FIELD_N; k++) begin
						if (field_of(due, k) != field_of(seen, k)) begin
							$error("%s: expected %0d, got %0d", field_label(k),
								field_of(due, k), field_of(seen, k));
							fail_tally = fail_tally + 1;
						end
					end
				end
			end
			if (in_valid && !in_stall) begin
				due = mix_sample(fwd, strafe, rotate, right_trigger, left_trigger,
					shoulder_stick, tilt_stick, twist_stick, claw_button, enable_button,
					disable_button, pad_connected, latch_q);
				latch_q = due.dis;
				words_q.push_back(due);
			end
			mismatches <= fail_tally;
			words_due <= words_q.size();
		end
	end

endmodule

@@ bench/tb_vectored_thruster_mixer.sv @@
// Test bench top of the vectored thruster mixer: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_vectored_thruster_mixer;
	import vtm_pkg::*;

	localparam int CLK_PERIOD      = 10;
	localparam int RESET_CYCLES    = 4;
	// random part: PHASES register settings, WORDS_PER_PHASE words each
	localparam int PHASES          = 9;
	localparam int WORDS_PER_PHASE = 167;
	// well above one word's whole computation plus the worst receiver stall and sender gap
	localparam int WATCHDOG_LIMIT  = 10000;
	localparam int DRAIN_CYCLES    = 400;
	localparam int NUM_REGS        = 7;
	// index past the register file, must be ignored by the block
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	// button bits as packed {claw, enable, disable, pad}
	localparam logic [3:0] BTN_PAD  = 4'b0001;
	localparam logic [3:0] BTN_DIS  = 4'b0010;
	localparam logic [3:0] BTN_EN   = 4'b0100;
	localparam logic [3:0] BTN_CLAW = 4'b1000;

	// per register, in index order: reset, legal span, full field width
	localparam int REG_RESET [NUM_REGS] = '{1638, 1500, 400, 6554, 819, 819, 8192};
	localparam int REG_LOW   [NUM_REGS] = '{0, 1000, 0, 0, 0, 0, 0};
	localparam int REG_HIGH  [NUM_REGS] = '{16384, 2000, 500, 16384, 16384, 16384, 16384};
	localparam int REG_FULL  [NUM_REGS] = '{32767, 2047, 511, 32767, 32767, 32767, 32767};

	localparam logic [15:0] AXIS_EDGE [5] = '{16'h8000, 16'hC000, 16'h0000, 16'h4000, 16'h7FFF};
	localparam logic [14:0] TRIG_EDGE [3] = '{15'h0000, 15'h4000, 15'h7FFF};

	typedef struct packed {
		logic signed [15:0] fwd;
		logic signed [15:0] strafe;
		logic signed [15:0] rotate;
		logic [14:0]        rt;
		logic [14:0]        lt;
		logic signed [15:0] sh;
		logic signed [15:0] tl;
		logic signed [15:0] tw;
		logic               claw;
		logic               en;
		logic               dis;
		logic               pad;
	} sample_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_stall;
	logic signed [15:0]    fwd;
	logic signed [15:0]    strafe;
	logic signed [15:0]    rotate;
	logic [14:0]           right_trigger;
	logic [14:0]           left_trigger;
	logic signed [15:0]    shoulder_stick;
	logic signed [15:0]    tilt_stick;
	logic signed [15:0]    twist_stick;
	logic                  claw_button;
	logic                  enable_button;
	logic                  disable_button;
	logic                  pad_connected;
	logic                  out_valid;
	logic                  out_stall;
	logic [PWM_W-1:0]      front_right_pwm;
	logic [PWM_W-1:0]      back_right_pwm;
	logic [PWM_W-1:0]      back_left_pwm;
	logic [PWM_W-1:0]      front_left_pwm;
	logic [PWM_W-1:0]      up_left_pwm;
	logic [PWM_W-1:0]      up_right_pwm;
	logic [PWM_W-1:0]      up_back_pwm;
	logic [PWM_W-1:0]      shoulder_pwm;
	logic [PWM_W-1:0]      tilt_pwm;
	logic [PWM_W-1:0]      twist_pwm;
	logic                  claw_cmd;
	logic                  disabled_flag;

	int                    mismatches;
	int                    words_due;
	// no random sender gaps and no new receiver stall stretches while set
	logic                  idle_off = 1'b0;
	int unsigned           quiet_cycles;

	always #(CLK_PERIOD / 2) clk = ~clk;

	vectored_thruster_mixer u_dut (.*);

	// monitor: predicts from accepted input words, checks accepted result words
	vtm_mix_checker u_checker (.*);

	// Gap length: mostly none or short, now and then a long one that can outlast
	// the block's whole computation.
	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 88)
			return $urandom_range(1, 8);
		if (roll < 97)
			return $urandom_range(9, 60);
		return $urandom_range(61, 400);
	endfunction

	// stick axis: mostly legal Q2.14, some near the deadband, some edges, some raw 16 bits
	function automatic logic [15:0] rand_axis();
		case ($urandom_range(0, 9))
			0:       return 16'($urandom);
			1:       return AXIS_EDGE[$urandom_range(0, 4)];
			2:       return 16'($urandom_range(0, 4000) - 2000);
			default: return 16'($urandom_range(0, 32768) - 16384);
		endcase
	endfunction

	function automatic logic [14:0] rand_trigger();
		case ($urandom_range(0, 9))
			0:       return 15'($urandom);
			1:       return TRIG_EDGE[$urandom_range(0, 2)];
			default: return 15'($urandom_range(0, 16384));
		endcase
	endfunction

	// Buttons are weighted so the disable latch spends about a third of the
	// run set: enough enabled words to exercise the mixing and the deadband.
	function automatic sample_t random_word();
		sample_t w;
		w.fwd = rand_axis();
		w.strafe = rand_axis();
		w.rotate = rand_axis();
		w.rt = rand_trigger();
		w.lt = rand_trigger();
		w.sh = rand_axis();
		w.tl = rand_axis();
		w.tw = rand_axis();
		w.claw = 1'($urandom_range(0, 1));
		w.en = ($urandom_range(0, 2) == 0);
		w.dis = ($urandom_range(0, 11) == 0);
		w.pad = ($urandom_range(0, 19) != 0);
		return w;
	endfunction

	function automatic sample_t word_of(input int f, s, r, rt, lt, sh, tl, tw,
		input logic [3:0] btn);
		sample_t w;
		w.fwd = f[15:0];
		w.strafe = s[15:0];
		w.rotate = r[15:0];
		w.rt = rt[14:0];
		w.lt = lt[14:0];
		w.sh = sh[15:0];
		w.tl = tl[15:0];
		w.tw = tw[15:0];
		{w.claw, w.en, w.dis, w.pad} = btn;
		return w;
	endfunction

	// Present one word at the falling edge and hold it until the block takes
	// it. Valid stays high into the next call when no gap is drawn, so it is
	// never dropped and raised in the same step.
	task automatic send_word(input sample_t s);
		int unsigned gap;
		@(negedge clk);
		in_valid <= 1'b1;
		fwd <= s.fwd;
		strafe <= s.strafe;
		rotate <= s.rotate;
		right_trigger <= s.rt;
		left_trigger <= s.lt;
		shoulder_stick <= s.sh;
		tilt_stick <= s.tl;
		twist_stick <= s.tw;
		claw_button <= s.claw;
		enable_button <= s.en;
		disable_button <= s.dis;
		pad_connected <= s.pad;
		do
			@(posedge clk);
		while (in_stall);
		gap = idle_off ? 0 : pick_gap();
		if (gap != 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// Sender goes quiet until every predicted word has been taken.
	task automatic hold_off();
		@(negedge clk);
		in_valid <= 1'b0;
		while (words_due != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Register setting per phase: explicit reset values, legal minima, legal
	// maxima, full field width, zero center and deadband with widest span
	// (output clamps low), then random settings, some outside the legal span.
	task automatic program_phase(input int p);
		int val;
		for (int i = 0; i < NUM_REGS; i++) begin
			case (p)
				0: val = REG_RESET[i];
				1: val = REG_LOW[i];
				2: val = REG_HIGH[i];
				3: val = REG_FULL[i];
				4: val = (i == REG_PWM_CENTER || i == REG_DEADBAND) ? 0 : REG_FULL[i];
				default: begin
					if ($urandom_range(0, 3) == 0)
						val = $urandom_range(0, REG_FULL[i]);
					else
						val = $urandom_range(REG_LOW[i], REG_HIGH[i]);
				end
			endcase
			write_reg(cfg_reg_t'(i), val[CFG_DATA_W-1:0]);
		end
	endtask

	// Receiver: stall stretches of random length, started at random; none is
	// started while idle_off is set.
	initial begin
		int unsigned hold;
		out_stall = 1'b0;
		hold = 0;
		forever begin
			@(negedge clk);
			if (hold != 0) begin
				hold = hold - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
				if (!idle_off && $urandom_range(0, 19) == 0)
					hold = pick_gap();
			end
		end
	end

	// Watchdog: a run of cycles with no transfer on any channel means a hang.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		// every block input at a known value from time zero
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		fwd = '0;
		strafe = '0;
		rotate = '0;
		right_trigger = '0;
		left_trigger = '0;
		shoulder_stick = '0;
		tilt_stick = '0;
		twist_stick = '0;
		claw_button = 1'b0;
		enable_button = 1'b0;
		disable_button = 1'b0;
		pad_connected = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// an index past the register file must leave the reset settings alone,
		// which the directed words below then show
		write_reg(REG_UNUSED, '1);

		// neutral sample, then each horizontal axis at full scale
		send_word(word_of(0, 0, 0, 0, 0, 0, 0, 0, BTN_PAD));
		send_word(word_of(16384, 0, 0, 0, 0, 0, 0, 0, BTN_PAD));
		send_word(word_of(-16384, 0, 0, 0, 0, 0, 0, 0, BTN_PAD));
		send_word(word_of(0, 16384, 0, 0, 0, 0, 0, 0, BTN_PAD));
		send_word(word_of(0, 0, -16384, 0, 0, 0, 0, 0, BTN_PAD));
		// diagonal and full mix push the horizontal group past one: normalized
		send_word(word_of(16384, 16384, 0, 0, 0, 0, 0, 0, BTN_PAD));
		send_word(word_of(16384, 16384, 16384, 0, 0, 0, 0, 0, BTN_PAD));
		// below and around the deadband
		send_word(word_of(1000, 0, 0, 0, 0, 0, 0, 0, BTN_PAD));
		send_word(word_of(3000, -2500, 1200, 0, 0, 0, 0, 0, BTN_PAD));
		// vertical group: each trigger, an over-range trigger, equal triggers
		send_word(word_of(0, 0, 0, 16384, 0, 0, 0, 0, BTN_PAD));
		send_word(word_of(0, 0, 0, 0, 16384, 0, 0, 0, BTN_PAD));
		send_word(word_of(0, 0, 0, 32767, 0, 0, 0, 0, BTN_PAD));
		send_word(word_of(0, 0, 0, 8000, 8000, 0, 0, 0, BTN_PAD));
		// arm axes at legal and full-width extremes
		send_word(word_of(0, 0, 0, 0, 0, 16384, -16384, 16384, BTN_PAD));
		send_word(word_of(0, 0, 0, 0, 0, -32768, 32767, -32768, BTN_PAD));
		// out-of-range drive on every horizontal axis, both signs
		send_word(word_of(-32768, -32768, -32768, 0, 32767, 0, 0, 0, BTN_PAD));
		send_word(word_of(32767, 32767, 32767, 32767, 0, 0, 0, 0, BTN_CLAW | BTN_PAD));
		// disable latch: set, hold, disable beating enable, missing pad, clear
		send_word(word_of(16384, 0, 0, 16384, 0, 0, 0, 0, BTN_DIS | BTN_PAD));
		send_word(word_of(16384, 0, 0, 16384, 0, 0, 0, 0, BTN_PAD));
		send_word(word_of(16384, 0, 0, 0, 0, 0, 0, 0, BTN_EN | BTN_DIS | BTN_PAD));
		send_word(word_of(16384, 0, 0, 0, 0, 0, 0, 0, BTN_EN));
		send_word(word_of(16384, 0, 0, 0, 0, 0, 0, 0, BTN_EN | BTN_PAD));
		send_word(word_of(-16384, 0, 0, 16384, 0, 0, 0, 0, BTN_CLAW | BTN_PAD));

		// random part: the block is drained before every new setting; one
		// phase runs with no random gaps or new stalls, and now and then the
		// sender waits for every outstanding result mid-phase
		for (int p = 0; p < PHASES; p++) begin
			hold_off();
			program_phase(p);
			idle_off = (p == 2);
			for (int n = 0; n < WORDS_PER_PHASE; n++) begin
				if ($urandom_range(0, 99) == 0)
					hold_off();
				send_word(random_word());
			end
		end
		idle_off = 1'b0;
		@(negedge clk) in_valid <= 1'b0;

		// wait out the last result, then a quiet stretch for stray words
		while (words_due != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && words_due == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
